// ===== rtl/sbpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_pkg
// Shared types, widths and constants of the spectrum bin pixel decimator.
// ----------------------------------------------------------------------------
package sbpd_pkg;

    localparam int HZ_W      = 25;
    localparam int ACC_W     = 26;
    localparam int PWR_W     = 8;
    localparam int COL_OUT_W = 8;
    localparam int TONE_W    = 12;
    localparam int K_W       = 4;
    localparam int NUM_W     = 12;
    localparam int DEN_W     = 5;
    localparam int LVL_W     = 7;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam int LINE_PIXELS_DEF = 240;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam logic [HZ_W-1:0]  BIN_HZ_RST    = 25'd78125;
    localparam logic [HZ_W-1:0]  PIXEL_HZ_RST  = 25'd83333;
    localparam logic [PWR_W-1:0] THRESHOLD_RST = 8'd0;
    localparam logic [K_W-1:0]   SMOOTH_RST    = 4'd0;
    localparam logic [7:0]       SQUELCH_RST   = 8'h9D;
    localparam logic             PEAK_EN_RST   = 1'b0;

    localparam int LEVEL_MUL = 120;
    localparam int LEVEL_OFS = 100;
    localparam int TONE_BASE = 400;
    localparam int TONE_SPAN = 2600 - 400;

    typedef enum logic [1:0] {
        KIND_BIN   = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_BIN_HZ    = 3'd0,
        REG_PIXEL_HZ  = 3'd1,
        REG_THRESHOLD = 3'd2,
        REG_SMOOTH    = 3'd3,
        REG_SQUELCH   = 3'd4,
        REG_PEAK_EN   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [HZ_W-1:0]  bin_hz;
        logic [HZ_W-1:0]  pixel_hz;
        logic [PWR_W-1:0] power_threshold;
        logic [K_W-1:0]   smooth_factor;
        logic [7:0]       squelch_db;
        logic             peak_enable;
        logic             peak_clear;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PWR_W-1:0] quot;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/sbpd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 240
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/sbpd_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_cfg
// APB register file: bin and pixel spans, threshold, smoothing, squelch, peak.
// ----------------------------------------------------------------------------
module sbpd_cfg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sbpd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [sbpd_pkg::APB_DW-1:0]  pwdata,
    output logic      [sbpd_pkg::APB_DW-1:0]  prdata,
    output logic                              pready,
    output sbpd_pkg::cfg_t                    cfg
);

    logic [sbpd_pkg::HZ_W-1:0]  bin_hz_reg, bin_hz_next;
    logic [sbpd_pkg::HZ_W-1:0]  pixel_hz_reg, pixel_hz_next;
    logic [sbpd_pkg::PWR_W-1:0] threshold_reg, threshold_next;
    logic [sbpd_pkg::K_W-1:0]   smooth_reg, smooth_next;
    logic [7:0]                 squelch_reg, squelch_next;
    logic                       peak_en_reg, peak_en_next;
    logic                       wr_en;
    logic                       peak_clear;
    sbpd_pkg::reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = sbpd_pkg::reg_idx_t'(paddr[4:2]);

    always_comb begin
        bin_hz_next    = bin_hz_reg;
        pixel_hz_next  = pixel_hz_reg;
        threshold_next = threshold_reg;
        smooth_next    = smooth_reg;
        squelch_next   = squelch_reg;
        peak_en_next   = peak_en_reg;
        peak_clear     = 1'b0;
        if (wr_en) begin
            unique case (idx) inside
                sbpd_pkg::REG_BIN_HZ: begin
                    bin_hz_next = pwdata[sbpd_pkg::HZ_W-1:0];
                end
                sbpd_pkg::REG_PIXEL_HZ: begin
                    pixel_hz_next = pwdata[sbpd_pkg::HZ_W-1:0];
                end
                sbpd_pkg::REG_THRESHOLD: begin
                    threshold_next = pwdata[sbpd_pkg::PWR_W-1:0];
                end
                sbpd_pkg::REG_SMOOTH: begin
                    smooth_next = pwdata[sbpd_pkg::K_W-1:0];
                end
                sbpd_pkg::REG_SQUELCH: begin
                    squelch_next = pwdata[7:0];
                end
                sbpd_pkg::REG_PEAK_EN: begin
                    peak_en_next = pwdata[0];
                end
                default: begin
                end
            endcase
            // a change of view drops the peak hold
            unique case (idx) inside
                sbpd_pkg::REG_THRESHOLD, sbpd_pkg::REG_SMOOTH,
                sbpd_pkg::REG_PEAK_EN: begin
                    peak_clear = 1'b1;
                end
                default: begin
                    peak_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_hz_reg    <= sbpd_pkg::BIN_HZ_RST;
            pixel_hz_reg  <= sbpd_pkg::PIXEL_HZ_RST;
            threshold_reg <= sbpd_pkg::THRESHOLD_RST;
            smooth_reg    <= sbpd_pkg::SMOOTH_RST;
            squelch_reg   <= sbpd_pkg::SQUELCH_RST;
            peak_en_reg   <= sbpd_pkg::PEAK_EN_RST;
        end else begin
            bin_hz_reg    <= bin_hz_next;
            pixel_hz_reg  <= pixel_hz_next;
            threshold_reg <= threshold_next;
            smooth_reg    <= smooth_next;
            squelch_reg   <= squelch_next;
            peak_en_reg   <= peak_en_next;
        end
    end

    always_comb begin
        unique case (idx) inside
            sbpd_pkg::REG_BIN_HZ:    prdata = sbpd_pkg::APB_DW'(bin_hz_reg);
            sbpd_pkg::REG_PIXEL_HZ:  prdata = sbpd_pkg::APB_DW'(pixel_hz_reg);
            sbpd_pkg::REG_THRESHOLD: prdata = sbpd_pkg::APB_DW'(threshold_reg);
            sbpd_pkg::REG_SMOOTH:    prdata = sbpd_pkg::APB_DW'(smooth_reg);
            sbpd_pkg::REG_SQUELCH:   prdata = sbpd_pkg::APB_DW'(squelch_reg);
            sbpd_pkg::REG_PEAK_EN:   prdata = sbpd_pkg::APB_DW'(peak_en_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb begin
        cfg.bin_hz          = bin_hz_reg;
        cfg.pixel_hz        = pixel_hz_reg;
        cfg.power_threshold = threshold_reg;
        cfg.smooth_factor   = smooth_reg;
        cfg.squelch_db      = squelch_reg;
        cfg.peak_enable     = peak_en_reg;
        cfg.peak_clear      = peak_clear;
    end

endmodule
`default_nettype wire

// ===== rtl/sbpd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_div
// Restoring divider for the column average, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module sbpd_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sbpd_pkg::div_req_t req,
    output sbpd_pkg::div_rsp_t      rsp
);

    logic [sbpd_pkg::NUM_W-1:0] rem_reg, rem_next;
    logic [sbpd_pkg::DEN_W-1:0] den_reg, den_next;
    logic [sbpd_pkg::PWR_W-1:0] quot_reg, quot_next;
    logic [1:0]                 step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [2:0]                 sh_hi, sh_lo;
    logic [sbpd_pkg::NUM_W-1:0] trial_hi, trial_lo, rem_mid;
    logic                       bit_hi, bit_lo;

    assign sh_hi    = {~step_reg, 1'b1};
    assign sh_lo    = {~step_reg, 1'b0};
    assign trial_hi = sbpd_pkg::NUM_W'(den_reg) << sh_hi;
    assign trial_lo = sbpd_pkg::NUM_W'(den_reg) << sh_lo;
    assign bit_hi   = rem_reg >= trial_hi;
    assign rem_mid  = bit_hi ? rem_reg - trial_hi : rem_reg;
    assign bit_lo   = rem_mid >= trial_lo;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = bit_lo ? rem_mid - trial_lo : rem_mid;
            quot_next = {quot_reg[sbpd_pkg::PWR_W-3:0], bit_hi, bit_lo};
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

`ifndef SYNTHESIS
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < sbpd_pkg::NUM_W'(den_reg)))
        else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

// ===== rtl/spectrum_bin_pixel_decimator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_bin_pixel_decimator
// Folds display-ordered spectrum bins into pixel columns with smoothing,
// peak hold and a squelch beep request.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A peak clear or unused kind is done in
// the idle state; a bin or fill that does not complete a pixel also passes
// the accumulate state, and one that completes a pixel goes on through the
// read of the column store, the weight multiply, the two-bit-per-cycle
// divider that forms the column average, the write back and the result.
// A finished result waits in an output register while the next item is
// taken. After reset a pass over all LINE_PIXELS columns zeroes the
// store, taking no item; register writes are taken throughout.
module spectrum_bin_pixel_decimator #(
    parameter int LINE_PIXELS = sbpd_pkg::LINE_PIXELS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_kind,
    input  wire logic [sbpd_pkg::PWR_W-1:0]        s_power,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [sbpd_pkg::PWR_W-1:0]        m_pixel_power,
    output logic      [sbpd_pkg::PWR_W-1:0]        m_smoothed_power,
    output logic      [sbpd_pkg::COL_OUT_W-1:0]    m_column,
    output logic                                   m_line_done,
    output logic                                   m_beep_request,
    output logic      [sbpd_pkg::TONE_W-1:0]       m_beep_tone_hz,
    output logic                                   m_peak_valid,
    output logic      [sbpd_pkg::COL_OUT_W-1:0]    m_peak_column,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sbpd_pkg::APB_AW-1:0]       paddr,
    input  wire logic [sbpd_pkg::APB_DW-1:0]       pwdata,
    output logic      [sbpd_pkg::APB_DW-1:0]       prdata,
    output logic                                   pready
);

    localparam int COL_W = $clog2(LINE_PIXELS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_PIXELS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } state_t;

    sbpd_pkg::cfg_t     cfg;
    sbpd_pkg::div_req_t div_req;
    sbpd_pkg::div_rsp_t div_rsp;

    state_t                        state_reg, state_next;
    logic [COL_W-1:0]              clr_addr_reg, clr_addr_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [sbpd_pkg::PWR_W-1:0]    power_reg, power_next;
    logic [sbpd_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [sbpd_pkg::PWR_W-1:0]    run_max_reg, run_max_next;
    logic [sbpd_pkg::PWR_W-1:0]    range_max_reg, range_max_next;
    logic [COL_W-1:0]              col_reg, col_next;
    logic [sbpd_pkg::PWR_W-1:0]    shown_reg, shown_next;
    logic [sbpd_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [sbpd_pkg::LVL_W-1:0]    lvl_reg, lvl_next;
    logic [sbpd_pkg::TONE_W-1:0]   tone_reg, tone_next;
    logic [sbpd_pkg::PWR_W-1:0]    peak_power_reg, peak_power_next;
    logic                          peak_seen_reg, peak_seen_next;
    logic [sbpd_pkg::COL_OUT_W-1:0] peak_col_reg, peak_col_next;

    logic                          m_valid_reg, m_valid_next;
    logic [sbpd_pkg::PWR_W-1:0]    m_pixel_reg, m_pixel_next;
    logic [sbpd_pkg::PWR_W-1:0]    m_smooth_reg, m_smooth_next;
    logic [sbpd_pkg::COL_OUT_W-1:0] m_col_reg, m_col_next;
    logic                          m_line_done_reg, m_line_done_next;
    logic                          m_beep_reg, m_beep_next;
    logic [sbpd_pkg::TONE_W-1:0]   m_tone_reg, m_tone_next;
    logic                          m_peak_valid_reg, m_peak_valid_next;
    logic [sbpd_pkg::COL_OUT_W-1:0] m_peak_col_reg, m_peak_col_next;

    logic                          ram_we;
    logic [COL_W-1:0]              ram_waddr;
    logic [sbpd_pkg::PWR_W-1:0]    ram_wdata;
    logic [sbpd_pkg::PWR_W-1:0]    ram_rdata;

    logic                          real_item;
    logic [sbpd_pkg::PWR_W-1:0]    run_max_upd, range_max_upd, shown_raw;
    logic [sbpd_pkg::ACC_W:0]      acc_sum;
    logic [sbpd_pkg::ACC_W-1:0]    acc_sat;
    logic                          pixel_hit;
    logic [COL_W+7:0]              col_ext;
    logic [sbpd_pkg::COL_OUT_W-1:0] col8;
    logic                          line_end;
    logic                          out_ok;
    logic                          out_load;
    logic                          peak_clr_item;
    logic [14:0]                   lvl_prod;
    logic [15:0]                   lvl_inc;
    logic [15:0]                   lvl_quot;
    logic [19:0]                   tone_prod;
    logic signed [9:0]             level_s, squelch_s;
    logic                          beep_hit;

    sbpd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbpd_ram #(
        .WIDTH (sbpd_pkg::PWR_W),
        .DEPTH (LINE_PIXELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    sbpd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // accumulate and max tracking
    assign real_item     = kind_reg == sbpd_pkg::KIND_BIN;
    assign run_max_upd   = (power_reg > run_max_reg) ? power_reg : run_max_reg;
    assign range_max_upd = (run_max_upd > range_max_reg) ? run_max_upd : range_max_reg;
    assign acc_sum       = {1'b0, acc_reg} + (sbpd_pkg::ACC_W + 1)'(cfg.bin_hz);
    assign acc_sat       = (acc_sum > {1'b0, sbpd_pkg::ACC_MAX}) ?
                           sbpd_pkg::ACC_MAX : acc_sum[sbpd_pkg::ACC_W-1:0];
    assign pixel_hit     = acc_sat >= sbpd_pkg::ACC_W'(cfg.pixel_hz);
    assign shown_raw     = real_item ? run_max_upd : power_reg;

    // line level: r*120/255 via exact reciprocal for 16-bit operands
    assign lvl_prod  = 15'(range_max_reg) * 15'(sbpd_pkg::LEVEL_MUL);
    assign lvl_inc   = 16'(lvl_prod) + 16'd1;
    assign lvl_quot  = (lvl_inc + (lvl_inc >> 8)) >> 8;
    assign tone_prod = 20'(range_max_reg) * 20'(sbpd_pkg::TONE_SPAN);

    assign level_s   = $signed(10'(lvl_reg)) - $signed(10'(sbpd_pkg::LEVEL_OFS));
    assign squelch_s = $signed({{2{cfg.squelch_db[7]}}, cfg.squelch_db});

    assign col_ext  = {8'b0, col_reg};
    assign col8     = col_ext[sbpd_pkg::COL_OUT_W-1:0];
    assign line_end = col_reg == LAST_COL;
    assign beep_hit = line_end && real_item && (level_s >= squelch_s);
    assign out_ok   = !m_valid_reg || m_ready;

    always_comb begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        kind_next         = kind_reg;
        power_next        = power_reg;
        acc_next          = acc_reg;
        run_max_next      = run_max_reg;
        range_max_next    = range_max_reg;
        col_next          = col_reg;
        shown_next        = shown_reg;
        num_next          = num_reg;
        lvl_next          = lvl_reg;
        tone_next         = tone_reg;
        peak_power_next   = peak_power_reg;
        peak_seen_next    = peak_seen_reg;
        peak_col_next     = peak_col_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_pixel_next      = m_pixel_reg;
        m_smooth_next     = m_smooth_reg;
        m_col_next        = m_col_reg;
        m_line_done_next  = m_line_done_reg;
        m_beep_next       = m_beep_reg;
        m_tone_next       = m_tone_reg;
        m_peak_valid_next = m_peak_valid_reg;
        m_peak_col_next   = m_peak_col_reg;
        div_req.start     = 1'b0;
        div_req.num       = num_reg;
        div_req.den       = sbpd_pkg::DEN_W'(cfg.smooth_factor) + 1'b1;
        ram_we            = 1'b0;
        ram_waddr         = col_reg;
        ram_wdata         = div_rsp.quot;
        out_load          = 1'b0;
        peak_clr_item     = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == LAST_COL) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    power_next = s_power;
                    case (s_kind) inside
                        sbpd_pkg::KIND_BIN, sbpd_pkg::KIND_FILL: begin
                            state_next = ST_ACC;
                        end
                        sbpd_pkg::KIND_CLEAR: begin
                            peak_clr_item = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ACC: begin
                acc_next = acc_sat;
                if (real_item) begin
                    run_max_next   = run_max_upd;
                    range_max_next = range_max_upd;
                end
                if (pixel_hit) begin
                    shown_next = (shown_raw > cfg.power_threshold) ? shown_raw : '0;
                    if (real_item) begin
                        run_max_next = '0;
                    end
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                num_next   = sbpd_pkg::NUM_W'(cfg.smooth_factor) *
                             sbpd_pkg::NUM_W'(ram_rdata) + sbpd_pkg::NUM_W'(shown_reg);
                lvl_next   = lvl_quot[sbpd_pkg::LVL_W-1:0];
                tone_next  = sbpd_pkg::TONE_W'(sbpd_pkg::TONE_BASE) +
                             sbpd_pkg::TONE_W'(tone_prod >> 8);
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                div_req.start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ok) begin
                    out_load = 1'b1;
                    ram_we   = 1'b1;
                    if (cfg.peak_enable &&
                        (!peak_seen_reg || div_rsp.quot > peak_power_reg)) begin
                        peak_power_next = div_rsp.quot;
                        peak_col_next   = col8;
                        peak_seen_next  = 1'b1;
                    end
                    m_valid_next      = 1'b1;
                    m_pixel_next      = shown_reg;
                    m_smooth_next     = div_rsp.quot;
                    m_col_next        = col8;
                    m_line_done_next  = line_end;
                    m_beep_next       = beep_hit;
                    m_tone_next       = beep_hit ? tone_reg : '0;
                    m_peak_valid_next = peak_seen_next;
                    m_peak_col_next   = peak_col_next;
                    if (line_end) begin
                        col_next = '0;
                        acc_next = '0;
                        if (real_item) begin
                            range_max_next = '0;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                        acc_next = acc_reg - sbpd_pkg::ACC_W'(cfg.pixel_hz);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (peak_clr_item || cfg.peak_clear) begin
            peak_power_next = '0;
            peak_seen_next  = 1'b0;
            peak_col_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            acc_reg          <= '0;
            run_max_reg      <= '0;
            range_max_reg    <= '0;
            col_reg          <= '0;
            peak_power_reg   <= '0;
            peak_seen_reg    <= 1'b0;
            peak_col_reg     <= '0;
            m_valid_reg      <= 1'b0;
            m_pixel_reg      <= '0;
            m_smooth_reg     <= '0;
            m_col_reg        <= '0;
            m_line_done_reg  <= 1'b0;
            m_beep_reg       <= 1'b0;
            m_tone_reg       <= '0;
            m_peak_valid_reg <= 1'b0;
            m_peak_col_reg   <= '0;
        end else begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            acc_reg          <= acc_next;
            run_max_reg      <= run_max_next;
            range_max_reg    <= range_max_next;
            col_reg          <= col_next;
            peak_power_reg   <= peak_power_next;
            peak_seen_reg    <= peak_seen_next;
            peak_col_reg     <= peak_col_next;
            m_valid_reg      <= m_valid_next;
            m_pixel_reg      <= m_pixel_next;
            m_smooth_reg     <= m_smooth_next;
            m_col_reg        <= m_col_next;
            m_line_done_reg  <= m_line_done_next;
            m_beep_reg       <= m_beep_next;
            m_tone_reg       <= m_tone_next;
            m_peak_valid_reg <= m_peak_valid_next;
            m_peak_col_reg   <= m_peak_col_next;
        end
    end

    // datapath temporaries
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        power_reg <= power_next;
        shown_reg <= shown_next;
        num_reg   <= num_next;
        lvl_reg   <= lvl_next;
        tone_reg  <= tone_next;
    end

    assign s_ready          = state_reg == ST_IDLE;
    assign m_valid          = m_valid_reg;
    assign m_pixel_power    = m_pixel_reg;
    assign m_smoothed_power = m_smooth_reg;
    assign m_column         = m_col_reg;
    assign m_line_done      = m_line_done_reg;
    assign m_beep_request   = m_beep_reg;
    assign m_beep_tone_hz   = m_tone_reg;
    assign m_peak_valid     = m_peak_valid_reg;
    assign m_peak_column    = m_peak_col_reg;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= LAST_COL)
        else $error("column counter beyond line");

    a_line_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && line_end) |=> (col_reg == '0 && acc_reg == '0))
        else $error("line end did not clear counter and accumulator");

    a_peak_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !peak_seen_reg |-> (peak_power_reg == '0 && peak_col_reg == '0))
        else $error("peak fields set without a recorded peak");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the spectrum bin pixel decimator. A table of directed items
// and register writes runs first. Random phases follow, each with fresh
// register settings. Every accepted item goes through a bit-exact column
// predictor. Every pixel the block hands out is checked field by field
// against the oldest pending expected result. Both handshakes idle at random,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpd_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int LINE_PIXELS   = LINE_PIXELS_DEF;
    localparam int HZ_FULL       = 2**HZ_W - 1;
    localparam int PWR_FULL      = 255;
    localparam int TONE_DIV      = 256;
    localparam int SQ_LO         = -99;
    localparam int SQ_HI         = 20;
    localparam int IDLE_PCT      = 15;
    localparam int SETTLE_CYCLES = 32;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int CALM_PHASE    = 3;
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [2:0] REG_NONE_LO = 3'd6;
    localparam logic [2:0] REG_NONE_HI = 3'd7;

    typedef struct packed {
        logic [PWR_W-1:0]     pixel_power;
        logic [PWR_W-1:0]     smoothed_power;
        logic [COL_OUT_W-1:0] column;
        logic                 line_done;
        logic                 beep_request;
        logic [TONE_W-1:0]    beep_tone_hz;
        logic                 peak_valid;
        logic [COL_OUT_W-1:0] peak_column;
    } column_result_t;

    typedef enum bit {ROW_CFG, ROW_ITEM} row_op_t;

    typedef struct {
        row_op_t          op;
        logic [2:0]       sel;
        logic [31:0]      value;
        logic [1:0]       kind;
        logic [PWR_W-1:0] power;
        bit               lit;
        column_result_t   want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_kind;
    logic [PWR_W-1:0]     s_power;
    logic                 m_valid;
    logic                 m_ready;
    logic [PWR_W-1:0]     m_pixel_power;
    logic [PWR_W-1:0]     m_smoothed_power;
    logic [COL_OUT_W-1:0] m_column;
    logic                 m_line_done;
    logic                 m_beep_request;
    logic [TONE_W-1:0]    m_beep_tone_hz;
    logic                 m_peak_valid;
    logic [COL_OUT_W-1:0] m_peak_column;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor configuration
    logic [HZ_W-1:0]      cfg_bin_hz    = BIN_HZ_RST;
    logic [HZ_W-1:0]      cfg_pixel_hz  = PIXEL_HZ_RST;
    logic [PWR_W-1:0]     cfg_threshold = THRESHOLD_RST;
    logic [K_W-1:0]       cfg_weight    = SMOOTH_RST;
    logic signed [7:0]    cfg_squelch   = SQUELCH_RST;
    logic                 cfg_peak_en   = PEAK_EN_RST;

    // predictor state
    logic [ACC_W-1:0]     hz_acc   = '0;
    logic [PWR_W-1:0]     bin_max  = '0;
    logic [PWR_W-1:0]     span_max = '0;
    int                   col_next = 0;
    logic [PWR_W-1:0]     col_avg [LINE_PIXELS];
    logic [PWR_W-1:0]     pk_power = '0;
    logic                 pk_seen  = 1'b0;
    logic [COL_OUT_W-1:0] pk_col   = '0;

    column_result_t pixels_due[$];
    int             mismatches   = 0;
    int             results_seen = 0;
    int             cycle_count  = 0;
    int             hold_left    = 0;
    bit             hold_done    = 1'b0;
    bit             calm         = 1'b0;

    spectrum_bin_pixel_decimator u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_power          (s_power),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_power    (m_pixel_power),
        .m_smoothed_power (m_smoothed_power),
        .m_column         (m_column),
        .m_line_done      (m_line_done),
        .m_beep_request   (m_beep_request),
        .m_beep_tone_hz   (m_beep_tone_hz),
        .m_peak_valid     (m_peak_valid),
        .m_peak_column    (m_peak_column),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic void drop_peak();
        pk_power = '0;
        pk_seen  = 1'b0;
        pk_col   = '0;
    endfunction

    function automatic void apply_reg(input logic [2:0] sel, input logic [31:0] value);
        case (sel)
            REG_BIN_HZ:   cfg_bin_hz   = value[HZ_W-1:0];
            REG_PIXEL_HZ: cfg_pixel_hz = value[HZ_W-1:0];
            REG_THRESHOLD: begin
                cfg_threshold = value[PWR_W-1:0];
                drop_peak();
            end
            REG_SMOOTH: begin
                cfg_weight = value[K_W-1:0];
                drop_peak();
            end
            REG_SQUELCH:  cfg_squelch  = value[7:0];
            REG_PEAK_EN: begin
                cfg_peak_en = value[0];
                drop_peak();
            end
            default: ;
        endcase
    endfunction

    // folds one item into the column state, returns 1 when a pixel comes out
    function automatic bit fold_item(input logic [1:0] kind, input logic [PWR_W-1:0] power,
                                     output column_result_t res);
        logic [ACC_W:0]   sum;
        logic [PWR_W-1:0] shown;
        int               col, avg, level, tone;
        bit               real_bin;
        res = '0;
        real_bin = (kind == KIND_BIN);
        if (kind == KIND_CLEAR) begin
            drop_peak();
            return 1'b0;
        end
        if (!real_bin && kind != KIND_FILL)
            return 1'b0;
        if (real_bin) begin
            if (power > bin_max)
                bin_max = power;
            if (bin_max > span_max)
                span_max = bin_max;
        end
        sum = hz_acc + cfg_bin_hz;
        hz_acc = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
        if (hz_acc < cfg_pixel_hz)
            return 1'b0;
        shown = real_bin ? bin_max : power;
        if (shown <= cfg_threshold)
            shown = '0;
        if (real_bin)
            bin_max = '0;
        col = (col_next >= LINE_PIXELS) ? 0 : col_next;
        avg = (int'(cfg_weight) * int'(col_avg[col]) + int'(shown)) / (int'(cfg_weight) + 1);
        col_avg[col] = avg[PWR_W-1:0];
        if (cfg_peak_en && (!pk_seen || avg > int'(pk_power))) begin
            pk_power = avg[PWR_W-1:0];
            pk_col   = col[COL_OUT_W-1:0];
            pk_seen  = 1'b1;
        end
        col_next = col + 1;
        res.pixel_power    = shown;
        res.smoothed_power = avg[PWR_W-1:0];
        res.column         = col[COL_OUT_W-1:0];
        if (col_next >= LINE_PIXELS) begin
            res.line_done = 1'b1;
            col_next = 0;
            hz_acc = '0;
            if (real_bin) begin
                level = int'(span_max) * LEVEL_MUL / PWR_FULL - LEVEL_OFS;
                if (level >= int'(cfg_squelch)) begin
                    tone = TONE_BASE + int'(span_max) * TONE_SPAN / TONE_DIV;
                    res.beep_request = 1'b1;
                    res.beep_tone_hz = tone[TONE_W-1:0];
                end
                span_max = '0;
            end
        end else begin
            hz_acc = hz_acc - cfg_pixel_hz;
        end
        res.peak_valid  = pk_seen;
        res.peak_column = pk_col;
        return 1'b1;
    endfunction

    function automatic column_result_t pixel_of(input int pix, input int sm, input int col,
                                                input int ld, input int bp, input int tone,
                                                input int pv, input int pc);
        column_result_t r;
        r.pixel_power    = pix[PWR_W-1:0];
        r.smoothed_power = sm[PWR_W-1:0];
        r.column         = col[COL_OUT_W-1:0];
        r.line_done      = ld[0];
        r.beep_request   = bp[0];
        r.beep_tone_hz   = tone[TONE_W-1:0];
        r.peak_valid     = pv[0];
        r.peak_column    = pc[COL_OUT_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [2:0] sel, input logic [31:0] value);
        stim_row_t r;
        r = '{op: ROW_CFG, sel: sel, value: value, kind: '0, power: '0, lit: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [1:0] kind, input logic [PWR_W-1:0] power);
        stim_row_t r;
        r = '{op: ROW_ITEM, sel: '0, value: '0, kind: kind, power: power, lit: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t lit_row(input logic [1:0] kind, input logic [PWR_W-1:0] power,
                                          input column_result_t want);
        stim_row_t r;
        r = '{op: ROW_ITEM, sel: '0, value: '0, kind: kind, power: power, lit: 1'b1, want: want};
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] sel, input logic [31:0] value);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            done = pready;
            @(posedge aclk);
        end while (!done);
        apply_reg(sel, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [PWR_W-1:0] power,
                             input bit lit, input column_result_t want);
        bit             taken;
        column_result_t predicted;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_power <= power;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        if (fold_item(kind, power, predicted))
            pixels_due = {pixels_due, (lit ? want : predicted)};
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge aclk) begin
        column_result_t due;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pixels_due.size() == 0) begin
                $error("pixel transaction with nothing pending, column %0d", m_column);
                mismatches++;
            end else begin
                due = pixels_due.pop_front();
                check_field("pixel_power", due.pixel_power, m_pixel_power);
                check_field("smoothed_power", due.smoothed_power, m_smoothed_power);
                check_field("column", due.column, m_column);
                check_field("line_done", due.line_done, m_line_done);
                check_field("beep_request", due.beep_request, m_beep_request);
                check_field("beep_tone_hz", due.beep_tone_hz, m_beep_tone_hz);
                check_field("peak_valid", due.peak_valid, m_peak_valid);
                check_field("peak_column", due.peak_column, m_peak_column);
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        stim_row_t        plan[$];
        int               sent, r, sq;
        logic [1:0]       kind;
        logic [PWR_W-1:0] power;
        logic [HZ_W-1:0]  hz_a, hz_b;

        foreach (col_avg[i])
            col_avg[i] = '0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_kind  <= '0;
        s_power <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one pixel per item, peak tracking on
        plan = {plan, cfg_row(REG_BIN_HZ, 32'd1)};
        plan = {plan, cfg_row(REG_PIXEL_HZ, 32'd1)};
        plan = {plan, cfg_row(REG_THRESHOLD, 32'd0)};
        plan = {plan, cfg_row(REG_SMOOTH, 32'd0)};
        plan = {plan, cfg_row(REG_SQUELCH, 32'(SQ_LO))};
        plan = {plan, cfg_row(REG_PEAK_EN, 32'd1)};
        plan = {plan, cfg_row(REG_NONE_LO, 32'hFFFF_FFFF)};
        plan = {plan, cfg_row(REG_NONE_HI, 32'h0000_0000)};
        plan = {plan, lit_row(KIND_BIN, 8'd255, pixel_of(255, 255, 0, 0, 0, 0, 1, 0))};
        plan = {plan, lit_row(KIND_BIN, 8'd0, pixel_of(0, 0, 1, 0, 0, 0, 1, 0))};
        plan = {plan, lit_row(KIND_FILL, 8'd128, pixel_of(128, 128, 2, 0, 0, 0, 1, 0))};
        plan = {plan, item_row(KIND_CLEAR, 8'd0)};
        plan = {plan, lit_row(KIND_BIN, 8'd10, pixel_of(10, 10, 3, 0, 0, 0, 1, 3))};
        plan = {plan, item_row(KIND_UNUSED, 8'd255)};
        plan = {plan, lit_row(KIND_FILL, 8'd0, pixel_of(0, 0, 4, 0, 0, 0, 1, 3))};
        plan = {plan, item_row(KIND_BIN, 8'd200)};
        plan = {plan, item_row(KIND_FILL, 8'd255)};
        plan = {plan, item_row(KIND_BIN, 8'd1)};
        // full threshold and weight, accumulator driven into saturation
        plan = {plan, cfg_row(REG_THRESHOLD, 32'd255)};
        plan = {plan, cfg_row(REG_SMOOTH, 32'd15)};
        plan = {plan, cfg_row(REG_SQUELCH, 32'(SQ_HI))};
        plan = {plan, cfg_row(REG_PEAK_EN, 32'd0)};
        plan = {plan, cfg_row(REG_BIN_HZ, 32'(HZ_FULL))};
        plan = {plan, cfg_row(REG_PIXEL_HZ, 32'd1)};
        plan = {plan, lit_row(KIND_BIN, 8'd255, pixel_of(0, 0, 8, 0, 0, 0, 0, 0))};
        plan = {plan, item_row(KIND_FILL, 8'd255)};
        plan = {plan, item_row(KIND_BIN, 8'd128)};
        plan = {plan, item_row(KIND_BIN, 8'd0)};
        plan = {plan, item_row(KIND_FILL, 8'd1)};
        // drain the saturated accumulator with the widest pixel
        plan = {plan, cfg_row(REG_THRESHOLD, 32'd254)};
        plan = {plan, cfg_row(REG_PEAK_EN, 32'd1)};
        plan = {plan, cfg_row(REG_BIN_HZ, 32'd1)};
        plan = {plan, cfg_row(REG_PIXEL_HZ, 32'(HZ_FULL))};
        plan = {plan, item_row(KIND_BIN, 8'd255)};
        plan = {plan, item_row(KIND_FILL, 8'd255)};
        plan = {plan, item_row(KIND_BIN, 8'd7)};
        plan = {plan, item_row(KIND_FILL, 8'd3)};

        foreach (plan[i]) begin
            if (plan[i].op == ROW_CFG) begin
                wait_idle();
                write_reg(plan[i].sel, plan[i].value);
            end else begin
                send_item(plan[i].kind, plan[i].power, plan[i].lit, plan[i].want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            calm = (ph == CALM_PHASE);
            case ($urandom_range(0, 2))
                0: begin
                    hz_a = HZ_W'($urandom_range(1, HZ_FULL));
                    hz_b = hz_a;
                end
                1: begin
                    hz_b = HZ_W'($urandom_range(1, HZ_FULL));
                    hz_a = HZ_W'(hz_b / $urandom_range(1, 3));
                    if (hz_a == 0)
                        hz_a = 1;
                end
                default: begin
                    hz_a = HZ_W'($urandom_range(1, HZ_FULL));
                    hz_b = HZ_W'($urandom_range(1, hz_a));
                end
            endcase
            write_reg(REG_BIN_HZ, 32'(hz_a));
            write_reg(REG_PIXEL_HZ, 32'(hz_b));
            r = $urandom_range(0, 9);
            write_reg(REG_THRESHOLD, (r < 4) ? 32'd0 : (r == 4) ? 32'd255 : $urandom_range(0, 255));
            write_reg(REG_SMOOTH, $urandom_range(0, 15));
            r = $urandom_range(0, 3);
            sq = (r == 0) ? SQ_LO : (r == 1) ? SQ_HI : $urandom_range(0, SQ_HI - SQ_LO) + SQ_LO;
            write_reg(REG_SQUELCH, 32'(sq));
            write_reg(REG_PEAK_EN, $urandom_range(0, 1));

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                kind = (r < 70) ? KIND_BIN : (r < 88) ? KIND_FILL :
                       (r < 95) ? KIND_CLEAR : KIND_UNUSED;
                r = $urandom_range(0, 9);
                power = (r == 0) ? '0 : (r == 1) ? '1 : 8'($urandom);
                send_item(kind, power, 1'b0, '0);
                if (kind != KIND_UNUSED)
                    sent++;
            end
        end
        calm = 1'b0;

        wait_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
